[src/rzs_pkg.sv]
// ---------------------------------------------------------------------------
// rzs_pkg: shared types and constants of the range zone selector
// Table geometry, item kind codes, register indexes and the table entry
// layout used by the controller, the table store and the top level.
// ---------------------------------------------------------------------------
package rzs_pkg;

  localparam int ENTRIES  = 16;
  localparam int SLOTS    = 16;
  localparam int SEARCH_N = (ENTRIES < SLOTS) ? ENTRIES : SLOTS;
  localparam int AW       = $clog2(SEARCH_N);
  localparam int CNT_W    = AW + 1;
  localparam int ZONE_W   = 4;
  localparam int IDX_W    = 4;
  localparam int BOUND_W  = 10;
  localparam int VAL_W    = 24;
  localparam int SAMPLE_W = 16;
  localparam int HYST_W   = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [BOUND_W-1:0] SAMPLE_MAX = BOUND_W'(1000);
  localparam logic [HYST_W-1:0]  HYST_RESET = HYST_W'(10);

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic REG_HYST = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic [VAL_W-1:0]   cur;
    logic [VAL_W-1:0]   volt;
  } entry_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    entry_t        data;
  } tbl_wr_t;

  typedef struct packed {
    logic [HYST_W-1:0] hyst;
    logic              mode;
  } cfg_t;

endpackage

[src/rzs_table.sv]
// ---------------------------------------------------------------------------
// rzs_table: zone table store
// One synchronous memory of entries with one write and one registered read
// port. Per-entry valid bits make unwritten entries read as all zero.
// ---------------------------------------------------------------------------
module rzs_table (
  input  logic                    clk,
  input  logic                    rst,
  input  rzs_pkg::tbl_wr_t        wr,
  input  logic [rzs_pkg::AW-1:0]  raddr,
  output rzs_pkg::entry_t         rdata
);
  import rzs_pkg::*;

  entry_t              mem [SEARCH_N];
  logic [SEARCH_N-1:0] vld;
  entry_t              rd_q;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q   <= mem[raddr];
    rd_vld <= vld[raddr];
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

[src/rzs_ctrl.sv]
// ---------------------------------------------------------------------------
// rzs_ctrl: item sequencer and zone decision
// Walks the table for the first entry holding the clamped sample, in mode 0
// applies hysteresis and step rules, then fetches the selected zone's values.
// ---------------------------------------------------------------------------
module rzs_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  rzs_pkg::cfg_t                cfg,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind,
  input  logic [rzs_pkg::IDX_W-1:0]    entry_index,
  input  logic [rzs_pkg::BOUND_W-1:0]  bound_a,
  input  logic [rzs_pkg::BOUND_W-1:0]  bound_b,
  input  logic [rzs_pkg::VAL_W-1:0]    limit_current,
  input  logic [rzs_pkg::VAL_W-1:0]    limit_voltage,
  input  logic signed [rzs_pkg::SAMPLE_W-1:0] sample,
  output rzs_pkg::tbl_wr_t             wr,
  output logic [rzs_pkg::AW-1:0]       raddr,
  input  rzs_pkg::entry_t              rdata,
  output logic                         done,
  output logic [rzs_pkg::ZONE_W-1:0]   zone,
  output logic                         zone_valid,
  output logic [rzs_pkg::VAL_W-1:0]    current_out,
  output logic [rzs_pkg::VAL_W-1:0]    voltage_out,
  output logic                         no_match,
  output logic                         zone_changed
);
  import rzs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_FETCH  = 5'b01000,
    S_LOAD   = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   issue_idx;
  logic               chk_vld;
  logic [AW-1:0]      chk_idx;
  logic [BOUND_W-1:0] x;
  logic [BOUND_W-1:0] x_clamp;
  logic               was_valid;
  logic [AW-1:0]      was_zone;
  logic               miss;
  logic [AW-1:0]      m_idx;
  logic [BOUND_W-1:0] m_lo;
  logic [BOUND_W-1:0] m_hi;
  logic [AW-1:0]      sel_zone;
  logic               sel_valid;
  logic [AW-1:0]      zone_next;
  logic               accept;
  logic               issue;
  logic               hit;
  logic               last_chk;

  function automatic logic holds(input logic [BOUND_W-1:0] a,
                                 input logic [BOUND_W-1:0] b,
                                 input logic [BOUND_W-1:0] v);
    if (a >= b) begin
      return (v <= a) && (v >= b);
    end
    return (v >= a) && (v <= b);
  endfunction

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign issue    = (issue_idx < CNT_W'(SEARCH_N));
  assign hit      = chk_vld && holds(rdata.lo, rdata.hi, x);
  assign last_chk = chk_vld && (chk_idx == AW'(SEARCH_N - 1));
  assign raddr    = (state == S_SCAN) ? issue_idx[AW-1:0] : sel_zone;

  always_comb begin
    if (sample < 0) begin
      x_clamp = '0;
    end else if (sample > SAMPLE_W'(SAMPLE_MAX)) begin
      x_clamp = SAMPLE_MAX;
    end else begin
      x_clamp = sample[BOUND_W-1:0];
    end
  end

  // Table writes happen in the accepting cycle; entries beyond the
  // searched range are dropped.
  always_comb begin
    wr.en        = accept && (kind == KIND_WRITE) &&
                   (32'(entry_index) < SEARCH_N);
    wr.addr      = entry_index[AW-1:0];
    wr.data.lo   = bound_a;
    wr.data.hi   = bound_b;
    wr.data.cur  = limit_current;
    wr.data.volt = limit_voltage;
  end

  // Zone decision from the first match and the current selection.
  always_comb begin
    logic [CNT_W-1:0] mw;
    logic [CNT_W-1:0] cw;
    logic [CNT_W-1:0] c_up;
    mw   = {1'b0, m_idx};
    cw   = {1'b0, sel_zone};
    c_up = cw + CNT_W'(1);
    zone_next = m_idx;
    if (sel_valid && !cfg.mode) begin
      if (mw == c_up) begin
        if ({1'b0, x} < ({1'b0, m_lo} + {3'b000, cfg.hyst})) begin
          zone_next = sel_zone;
        end
      end else if ((sel_zone != '0) && (mw + CNT_W'(1) == cw)) begin
        if (({1'b0, x} + {3'b000, cfg.hyst}) > {1'b0, m_hi}) begin
          zone_next = sel_zone;
        end
      end else if (mw > c_up) begin
        zone_next = c_up[AW-1:0];
      end else if (mw + CNT_W'(1) < cw) begin
        zone_next = sel_zone - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_idx <= '0;
      chk_vld   <= 1'b0;
      sel_zone  <= '0;
      sel_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          issue_idx <= '0;
          chk_vld   <= 1'b0;
          if (accept) begin
            if (kind == KIND_SAMPLE) begin
              state <= S_SCAN;
            end else begin
              if (kind == KIND_CLEAR) begin
                sel_valid <= 1'b0;
                sel_zone  <= '0;
              end
              state <= S_FETCH;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= issue;
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (hit) begin
            state <= S_DECIDE;
          end else if (last_chk) begin
            sel_valid <= 1'b0;
            sel_zone  <= '0;
            state     <= S_FETCH;
          end
        end
        S_DECIDE: begin
          sel_zone  <= zone_next;
          sel_valid <= 1'b1;
          state     <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x         <= x_clamp;
      was_valid <= sel_valid;
      was_zone  <= sel_zone;
      miss      <= 1'b0;
    end
    if (state == S_SCAN) begin
      chk_idx <= issue_idx[AW-1:0];
      if (hit) begin
        m_idx <= chk_idx;
        m_lo  <= rdata.lo;
        m_hi  <= rdata.hi;
      end else if (last_chk) begin
        miss <= 1'b1;
      end
    end
    if (state == S_LOAD) begin
      zone         <= ZONE_W'(sel_zone);
      zone_valid   <= sel_valid;
      current_out  <= sel_valid ? rdata.cur : '0;
      voltage_out  <= sel_valid ? rdata.volt : '0;
      no_match     <= miss;
      zone_changed <= (was_valid != sel_valid) ||
                      (sel_valid && (was_zone != sel_zone));
    end
  end

endmodule

[src/range_zone_selector_hysteresis_core.sv]
// ---------------------------------------------------------------------------
// range_zone_selector_hysteresis_core: range zone selector with hysteresis
// Selects a zone from a table of ranges for each sample and reports the
// zone's current limit and float voltage.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. kind selects a
//   sample, a table write or a clear of the selection. Exactly one result
//   per item appears on the result ports for one cycle with done high; the
//   receiver cannot stall it, so it must be captured in that cycle.
//   A sample walks the table one entry per cycle through the read port of
//   the table memory, stopping at the first match; a match then takes a
//   decision step, and the sample ends with a fetch of the selected zone's
//   values. The next item can be taken in the cycle done is shown.
//   Reset clears the table to all zero, deselects the zone and loads the
//   registers with hysteresis 10 and mode 0. Registers are written through
//   the APB port (hysteresis at byte 0, mode at byte 4). The user must write
//   them only while the block is idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module range_zone_selector_hysteresis_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rzs_pkg::PADDR_W-1:0]         paddr,
  input  logic [rzs_pkg::PDATA_W-1:0]         pwdata,
  output logic [rzs_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind,
  input  logic [rzs_pkg::IDX_W-1:0]           entry_index,
  input  logic [rzs_pkg::BOUND_W-1:0]         bound_a,
  input  logic [rzs_pkg::BOUND_W-1:0]         bound_b,
  input  logic [rzs_pkg::VAL_W-1:0]           limit_current,
  input  logic [rzs_pkg::VAL_W-1:0]           limit_voltage,
  input  logic signed [rzs_pkg::SAMPLE_W-1:0] sample,
  output logic                                done,
  output logic [rzs_pkg::ZONE_W-1:0]          zone,
  output logic                                zone_valid,
  output logic [rzs_pkg::VAL_W-1:0]           current_out,
  output logic [rzs_pkg::VAL_W-1:0]           voltage_out,
  output logic                                no_match,
  output logic                                zone_changed
);
  import rzs_pkg::*;

  cfg_t          cfg;
  tbl_wr_t       wr;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic          reg_wr;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hyst <= HYST_RESET;
      cfg.mode <= 1'b0;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_HYST: cfg.hyst <= pwdata[HYST_W-1:0];
        REG_MODE: cfg.mode <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HYST: prdata = PDATA_W'(cfg.hyst);
      REG_MODE: prdata = PDATA_W'(cfg.mode);
      default:  prdata = '0;
    endcase
  end

  rzs_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  rzs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .entry_index   (entry_index),
    .bound_a       (bound_a),
    .bound_b       (bound_b),
    .limit_current (limit_current),
    .limit_voltage (limit_voltage),
    .sample        (sample),
    .wr            (wr),
    .raddr         (raddr),
    .rdata         (rdata),
    .done          (done),
    .zone          (zone),
    .zone_valid    (zone_valid),
    .current_out   (current_out),
    .voltage_out   (voltage_out),
    .no_match      (no_match),
    .zone_changed  (zone_changed)
  );

endmodule

[src/rzs_checker.sv]
// ---------------------------------------------------------------------------
// rzs_checker: port-level checks of the zone selector
// Watches the item handshake and the result ports of the top level.
// ---------------------------------------------------------------------------
module rzs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [rzs_pkg::ZONE_W-1:0] zone,
  input logic                       zone_valid,
  input logic [rzs_pkg::VAL_W-1:0]  current_out,
  input logic [rzs_pkg::VAL_W-1:0]  voltage_out,
  input logic                       no_match
);

  // An accepted item keeps the block busy until its result is shown.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the block is still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_no_zone_zero: assert property (@(posedge clk) disable iff (rst)
    done && !zone_valid |-> (zone == '0) && (current_out == '0) &&
                            (voltage_out == '0))
    else $error("deselected zone reports nonzero values");

  a_miss_invalid: assert property (@(posedge clk) disable iff (rst)
    done && no_match |-> !zone_valid)
    else $error("no match reported with a zone selected");

endmodule

bind range_zone_selector_hysteresis_core rzs_checker u_rzs_checker (.*);

[dv/zone_result_checker.sv]
// ---------------------------------------------------------------------------
// zone_result_checker: result checker for the range zone selector
// Watches the item, result and register ports, keeps its own copy of the
// zone table, the selection and the registers, predicts the result of every
// accepted item and compares each strobed result with the oldest prediction.
// ---------------------------------------------------------------------------
module zone_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rzs_pkg::PADDR_W-1:0]         paddr,
  input  logic [rzs_pkg::PDATA_W-1:0]         pwdata,
  input  logic                                pready,
  input  logic                                start,
  input  logic                                busy,
  input  logic [1:0]                          kind,
  input  logic [rzs_pkg::IDX_W-1:0]           entry_index,
  input  logic [rzs_pkg::BOUND_W-1:0]         bound_a,
  input  logic [rzs_pkg::BOUND_W-1:0]         bound_b,
  input  logic [rzs_pkg::VAL_W-1:0]           limit_current,
  input  logic [rzs_pkg::VAL_W-1:0]           limit_voltage,
  input  logic signed [rzs_pkg::SAMPLE_W-1:0] sample,
  input  logic                                done,
  input  logic [rzs_pkg::ZONE_W-1:0]          zone,
  input  logic                                zone_valid,
  input  logic [rzs_pkg::VAL_W-1:0]           current_out,
  input  logic [rzs_pkg::VAL_W-1:0]           voltage_out,
  input  logic                                no_match,
  input  logic                                zone_changed,
  output int                                  fail_count,
  output int                                  pending
);
  import rzs_pkg::*;

  typedef struct {
    logic [ZONE_W-1:0] zone;
    logic              valid;
    logic [VAL_W-1:0]  cur;
    logic [VAL_W-1:0]  volt;
    logic              miss;
    logic              changed;
  } zone_result_t;

  entry_t            zone_tbl [SLOTS];
  cfg_t              cfg;
  logic [ZONE_W-1:0] sel_zone;
  logic              sel_valid;
  zone_result_t      expected_q [$];
  int                errors = 0;

  // Advances the selection by one item and returns the result it reports.
  function automatic zone_result_t select_zone(
    input logic [1:0]                 k,
    input logic [IDX_W-1:0]           idx,
    input logic [BOUND_W-1:0]         a,
    input logic [BOUND_W-1:0]         b,
    input logic [VAL_W-1:0]           cur,
    input logic [VAL_W-1:0]           volt,
    input logic signed [SAMPLE_W-1:0] smp
  );
    zone_result_t      r;
    logic              was_valid;
    logic [ZONE_W-1:0] was_zone;
    int                x, m, c, ra, rb, i;
    was_valid = sel_valid;
    was_zone  = sel_zone;
    r.miss    = 1'b0;
    case (k)
      KIND_SAMPLE: begin
        x = smp;
        if (x < 0) x = 0;
        else if (x > int'(SAMPLE_MAX)) x = int'(SAMPLE_MAX);
        m = -1;
        for (i = SEARCH_N - 1; i >= 0; i--) begin
          ra = int'(zone_tbl[i].lo);
          rb = int'(zone_tbl[i].hi);
          if ((ra >= rb) ? (x <= ra && x >= rb) : (x >= ra && x <= rb)) m = i;
        end
        if (m < 0) begin
          sel_valid = 1'b0;
          sel_zone  = '0;
          r.miss    = 1'b1;
        end else if (!sel_valid || cfg.mode) begin
          sel_zone  = ZONE_W'(m);
          sel_valid = 1'b1;
        end else begin
          // Neighbors need the margin; anything farther is one step away.
          c = int'(sel_zone);
          if (m == c + 1) begin
            if (x < int'(zone_tbl[m].lo) + int'(cfg.hyst)) m = c;
          end else if (m == c - 1) begin
            if (x > int'(zone_tbl[m].hi) - int'(cfg.hyst)) m = c;
          end else if (m > c + 1) begin
            m = c + 1;
          end else if (m < c - 1) begin
            m = c - 1;
          end
          sel_zone = ZONE_W'(m);
        end
      end
      KIND_WRITE: begin
        if (int'(idx) < SEARCH_N) zone_tbl[idx] = '{lo: a, hi: b, cur: cur, volt: volt};
      end
      KIND_CLEAR: begin
        sel_valid = 1'b0;
        sel_zone  = '0;
      end
      default: ;
    endcase
    if (was_valid != sel_valid) r.changed = 1'b1;
    else r.changed = sel_valid && (was_zone != sel_zone);
    r.zone  = sel_valid ? sel_zone : '0;
    r.valid = sel_valid;
    r.cur   = sel_valid ? zone_tbl[sel_zone].cur : '0;
    r.volt  = sel_valid ? zone_tbl[sel_zone].volt : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    zone_result_t want;
    if (rst) begin
      foreach (zone_tbl[i]) zone_tbl[i] = '0;
      cfg.hyst  = HYST_RESET;
      cfg.mode  = 1'b0;
      sel_zone  = '0;
      sel_valid = 1'b0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: zone result with no item outstanding, expected none actual zone %0h",
                   $time, zone);
        end else begin
          want = expected_q.pop_front();
          check_field("zone", VAL_W'(want.zone), VAL_W'(zone));
          check_field("zone_valid", VAL_W'(want.valid), VAL_W'(zone_valid));
          check_field("current_out", want.cur, current_out);
          check_field("voltage_out", want.volt, voltage_out);
          check_field("no_match", VAL_W'(want.miss), VAL_W'(no_match));
          check_field("zone_changed", VAL_W'(want.changed), VAL_W'(zone_changed));
        end
      end
      if (start && !busy)
        expected_q.push_back(select_zone(kind, entry_index, bound_a, bound_b,
                                         limit_current, limit_voltage, sample));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HYST) cfg.hyst = pwdata[HYST_W-1:0];
        else cfg.mode = pwdata[0];
      end
    end
    fail_count <= errors;
    pending    <= expected_q.size();
  end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: top level testbench of the range zone selector
// Resets the block, runs a short directed sequence and then phases of table
// loads and drifting samples under changing register settings, with random
// gaps between items. A separate checker predicts and compares the results.
// ---------------------------------------------------------------------------
module testbench;
  import rzs_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                 kind;
    logic [IDX_W-1:0]           idx;
    logic [BOUND_W-1:0]         a;
    logic [BOUND_W-1:0]         b;
    logic [VAL_W-1:0]           cur;
    logic [VAL_W-1:0]           volt;
    logic signed [SAMPLE_W-1:0] smp;
  } zone_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 kind = KIND_SAMPLE;
  logic [IDX_W-1:0]           entry_index = '0;
  logic [BOUND_W-1:0]         bound_a = '0;
  logic [BOUND_W-1:0]         bound_b = '0;
  logic [VAL_W-1:0]           limit_current = '0;
  logic [VAL_W-1:0]           limit_voltage = '0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       done;
  logic [ZONE_W-1:0]          zone;
  logic                       zone_valid;
  logic [VAL_W-1:0]           current_out;
  logic [VAL_W-1:0]           voltage_out;
  logic                       no_match;
  logic                       zone_changed;
  int                         fail_count;
  int                         pending;
  int                         calm_left = 0;

  always #2 clk = ~clk;

  range_zone_selector_hysteresis_core dut (.*);

  zone_result_checker u_zone_chk (.*);

  function automatic zone_item_t rand_fields();
    zone_item_t it;
    it.kind = KIND_SAMPLE;
    it.idx  = IDX_W'($urandom);
    it.a    = BOUND_W'($urandom);
    it.b    = BOUND_W'($urandom);
    it.cur  = VAL_W'($urandom);
    it.volt = VAL_W'($urandom);
    it.smp  = SAMPLE_W'($urandom);
    return it;
  endfunction

  function automatic zone_item_t make_sample(input int v);
    zone_item_t it;
    it      = rand_fields();
    it.smp  = SAMPLE_W'(v);
    return it;
  endfunction

  function automatic zone_item_t make_kind(input logic [1:0] k);
    zone_item_t it;
    it      = rand_fields();
    it.kind = k;
    return it;
  endfunction

  function automatic zone_item_t make_write(input int idx, input int a, input int b,
                                            input logic [VAL_W-1:0] cur,
                                            input logic [VAL_W-1:0] volt);
    zone_item_t it;
    it      = rand_fields();
    it.kind = KIND_WRITE;
    it.idx  = IDX_W'(idx);
    it.a    = BOUND_W'(a);
    it.b    = BOUND_W'(b);
    it.cur  = cur;
    it.volt = volt;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a back-to-back item keeps it high.
  task automatic send_item(input zone_item_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind          <= it.kind;
    entry_index   <= it.idx;
    bound_a       <= it.a;
    bound_b       <= it.b;
    limit_current <= it.cur;
    limit_voltage <= it.volt;
    sample        <= it.smp;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drops start and waits until every outstanding item has reported.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic reg_idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    zone_item_t it;
    int zones, base, top_edge, span, lo, hi, r, walk;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fresh table: every entry is 0..0, so only a clamped-to-zero sample hits.
    send_item(make_sample(0));
    send_item(make_sample(-32768));
    send_item(make_sample(32767));
    send_item(make_kind(KIND_UNUSED));
    send_item(make_write(0, 199, 0, 24'hFFFFFF, 24'h000000));
    send_item(make_write(1, 200, 399, 24'h000000, 24'hFFFFFF));
    send_item(make_write(2, 400, 599, 24'h0A0B0C, 24'h3D0900));
    send_item(make_write(3, 600, 799, 24'h123456, 24'h654321));
    send_item(make_write(15, 1023, 800, 24'h5A5A5A, 24'hA5A5A5));
    send_item(make_sample(100));
    send_item(make_sample(205));
    send_item(make_sample(215));
    send_item(make_sample(395));
    send_item(make_sample(195));
    // A far match only moves the zone one step per sample.
    send_item(make_sample(1000));
    send_item(make_sample(1000));
    send_item(make_kind(KIND_CLEAR));
    send_item(make_kind(KIND_CLEAR));
    send_item(make_sample(700));
    send_item(make_sample(-1));
    send_item(make_write(0, 1023, 1023, 24'hFFFFFF, 24'hFFFFFF));
    send_item(make_sample(32767));
    settle();
    reg_write(REG_MODE, 32'd1);
    reg_write(REG_HYST, 32'd255);
    send_item(make_sample(0));
    send_item(make_sample(500));

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      if (phase == 0) reg_write(REG_HYST, 32'd0);
      else if (phase == 1) reg_write(REG_HYST, 32'd255);
      else reg_write(REG_HYST, PDATA_W'($urandom_range(0, 255)));
      if (phase == 3) reg_write(REG_MODE, 32'd1);
      else if (phase >= 4) reg_write(REG_MODE, {$urandom} & 32'hFFFF_FFFF);
      else reg_write(REG_MODE, 32'd0);

      // Contiguous ascending zones, sometimes with overlaps, swapped bounds or
      // uncovered ends; spare entries sit above the clamp and never match.
      zones    = $urandom_range(2, 16);
      base     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
      top_edge = ($urandom_range(0, 3) == 0) ? $urandom_range(850, 990) : 1000;
      span     = (top_edge - base + 1) / zones;
      for (int i = 0; i < SEARCH_N; i++) begin
        if (i < zones) begin
          lo = base + i * span;
          hi = (i == zones - 1) ? top_edge : lo + span - 1;
          if ($urandom_range(0, 4) == 0) hi = hi + $urandom_range(1, 20);
          if (hi > 1023) hi = 1023;
        end else begin
          lo = $urandom_range(1001, 1023);
          hi = $urandom_range(1001, 1023);
        end
        if ($urandom_range(0, 7) == 0)
          send_item(make_write(i, hi, lo, VAL_W'($urandom), VAL_W'($urandom)));
        else
          send_item(make_write(i, lo, hi, VAL_W'($urandom), VAL_W'($urandom)));
      end

      walk = $urandom_range(0, 1000);
      repeat (110) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          walk = walk + $urandom_range(0, 60) - 30;
          if (walk < -100) walk = -100;
          if (walk > 1100) walk = 1100;
          send_item(make_sample(walk));
        end else if (r < 84) begin
          send_item(rand_fields());
        end else if (r < 90) begin
          send_item(make_kind(KIND_CLEAR));
        end else if (r < 93) begin
          send_item(make_kind(KIND_UNUSED));
        end else begin
          it      = rand_fields();
          it.kind = KIND_WRITE;
          send_item(it);
        end
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/rzs_pkg.sv
src/rzs_table.sv
src/rzs_ctrl.sv
src/range_zone_selector_hysteresis_core.sv
src/rzs_checker.sv
dv/zone_result_checker.sv
dv/testbench.sv
